FILE: hw/rtl/text_console_cursor_scroll_assert.svh
// assertion macros for the text console
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// checked at every rising edge outside reset
`define TCCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define TCCS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hw/rtl/tccs_pkg.sv
// shared constants and types of the text console
package tccs_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int TAB_STEP   = 8;

   localparam int CELL_AW    = $clog2(CELLS);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int POS_W      = 11;
   localparam int WORD_W     = 16;

   typedef logic [WORD_W-1:0] cell_type;

   localparam logic [COL_W-1:0]   COL_LAST     = COL_W'(COLUMNS - 1);
   localparam logic [COL_W:0]     COLS_WIDE    = (COL_W+1)'(COLUMNS);
   localparam logic [COL_W:0]     TAB_ADD      = (COL_W+1)'(TAB_STEP);
   localparam logic [COL_W:0]     TAB_MASK     = ~((COL_W+1)'(TAB_STEP - 1));
   localparam logic [ROW_W-1:0]   ROW_LAST     = ROW_W'(ROWS - 1);
   localparam logic [CELL_AW-1:0] CELL_LAST    = CELL_AW'(CELLS - 1);
   localparam logic [CELL_AW-1:0] COLS_CELL    = CELL_AW'(COLUMNS);
   localparam logic [CELL_AW-1:0] FILL_FIRST   = CELL_AW'((ROWS - 1) * COLUMNS);

   // operation codes
   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // character codes
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BLANK = 8'h20;

   localparam logic [7:0] ATTR_RESET = 8'h0F;

endpackage

FILE: hw/rtl/tccs_ram.sv
// generic simple dual port ram with registered read
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/text_console_cursor_scroll.sv
// text console top level: cell memory, cursor, scroll and clear sequencer
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+---------------------------
//   request | req_mode, req_char_code,            | start while busy is low
//           | req_read_address                    |
//   result  | rsp_cursor_position, rsp_read_word  | rsp_valid, one cycle strobe
//   csr     | csr_attribute                       | csr_valid and csr_ready
//
// a request is latched at accept; a put of a plain character or control code
// is done in the execute state, a cell read also waits for the ram read
// a put that runs off the last row scrolls: the rows below the top move
// one row up on the single ram read and write ports, then the bottom row
// is blanked once the last moved word is written; a clear writes one cell
// a cycle; no new request is taken until the current one is done
// reset homes the cursor and sets the attribute to 0x0f; the cell memory is
// not cleared, a clear transaction must come before cells are read
// the receiver cannot stall: each result stands for exactly one cycle
`include "text_console_cursor_scroll_assert.svh"

module text_console_cursor_scroll
   import tccs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_char_code,
   input  logic [10:0]       req_read_address,

   output logic              rsp_valid,
   output logic [POS_W-1:0]  rsp_cursor_position,
   output logic [WORD_W-1:0] rsp_read_word,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_attribute
);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [7:0]         attr_ff;
   logic [CELL_AW-1:0] scan_ff, scan_in;
   logic               move_vld_ff, move_vld_in;
   logic [CELL_AW-1:0] move_addr_ff, move_addr_in;
   logic               rd_ok_ff, rd_ok_in;

   // latched request transaction
   logic [1:0]         mode_ff;
   logic [7:0]         char_ff;
   logic [10:0]        raddr_ff;

   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [WORD_W-1:0]  rsp_word_ff;

   logic               accept;
   logic               done;
   logic [WORD_W-1:0]  word_in;
   logic [CELL_AW-1:0] pos_in;
   logic [CELL_AW-1:0] cur_addr;
   logic [COL_W:0]     tab_col;
   logic               adv_row;
   cell_type           blank;

   logic               ram_we;
   logic [CELL_AW-1:0] ram_waddr;
   cell_type           ram_wdata;
   logic               ram_re;
   logic [CELL_AW-1:0] ram_raddr;
   cell_type           ram_rdata;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   assign blank    = {attr_ff, CH_BLANK};
   assign cur_addr = CELL_AW'(row_ff) * COLS_CELL + CELL_AW'(col_ff);
   assign tab_col  = ({1'b0, col_ff} + TAB_ADD) & TAB_MASK;
   assign pos_in   = CELL_AW'(row_in) * COLS_CELL + CELL_AW'(col_in);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      scan_in      = scan_ff;
      move_vld_in  = 1'b0;
      move_addr_in = move_addr_ff;
      rd_ok_in     = rd_ok_ff;
      done         = 1'b0;
      word_in      = '0;
      adv_row      = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = scan_ff;
      // a moved word lands one row up in the cycle after its read
      ram_we       = move_vld_ff;
      ram_waddr    = move_addr_ff;
      ram_wdata    = ram_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (mode_ff)
               MODE_PUT: begin
                  priority if (char_ff == CH_BS) begin
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end
                  end else if (char_ff == CH_TAB) begin
                     if (tab_col >= COLS_WIDE) begin
                        col_in  = '0;
                        adv_row = 1'b1;
                     end else begin
                        col_in = tab_col[COL_W-1:0];
                     end
                  end else if (char_ff == CH_CR) begin
                     col_in = '0;
                  end else if (char_ff == CH_LF) begin
                     col_in  = '0;
                     adv_row = 1'b1;
                  end else if (char_ff >= CH_BLANK) begin
                     ram_we    = 1'b1;
                     ram_waddr = cur_addr;
                     ram_wdata = {attr_ff, char_ff};
                     if (col_ff == COL_LAST) begin
                        col_in  = '0;
                        adv_row = 1'b1;
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end else begin
                     col_in = col_ff;
                  end
                  if (adv_row && (row_ff == ROW_LAST)) begin
                     // off the bottom: row stays, screen moves up
                     state_in = S_SCROLL;
                     scan_in  = COLS_CELL;
                  end else begin
                     if (adv_row) begin
                        row_in = row_ff + ROW_W'(1);
                     end
                     state_in = S_IDLE;
                     done     = 1'b1;
                  end
               end
               MODE_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  scan_in  = '0;
                  state_in = S_CLEAR;
               end
               MODE_READ: begin
                  ram_re    = 1'b1;
                  ram_raddr = CELL_AW'(raddr_ff);
                  rd_ok_in  = (32'(raddr_ff) < 32'(CELLS));
                  state_in  = S_READ;
               end
               default: begin
                  state_in = S_IDLE;
                  done     = 1'b1;
               end
            endcase
         end
         S_READ: begin
            word_in  = rd_ok_ff ? ram_rdata : '0;
            state_in = S_IDLE;
            done     = 1'b1;
         end
         S_SCROLL: begin
            // read one row ahead of the write, so no entry is read after its rewrite
            ram_re       = 1'b1;
            ram_raddr    = scan_ff;
            move_vld_in  = 1'b1;
            move_addr_in = scan_ff - COLS_CELL;
            if (scan_ff == CELL_LAST) begin
               state_in = S_FILL;
               scan_in  = FILL_FIRST;
            end else begin
               scan_in = scan_ff + CELL_AW'(1);
            end
         end
         S_FILL: begin
            // the last moved word owns the write port in the first cycle
            if (!move_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = scan_ff;
               ram_wdata = blank;
               if (scan_ff == CELL_LAST) begin
                  state_in = S_IDLE;
                  done     = 1'b1;
               end else begin
                  scan_in = scan_ff + CELL_AW'(1);
               end
            end
         end
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff;
            ram_wdata = blank;
            if (scan_ff == CELL_LAST) begin
               state_in = S_IDLE;
               done     = 1'b1;
            end else begin
               scan_in = scan_ff + CELL_AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         move_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         move_vld_ff  <= move_vld_in;
         rsp_valid_ff <= done;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_attribute;
         end
      end
   end

   // payload and counters
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      move_addr_ff <= move_addr_in;
      rd_ok_ff     <= rd_ok_in;
      if (accept) begin
         mode_ff  <= req_mode;
         char_ff  <= req_char_code;
         raddr_ff <= req_read_address;
      end
      if (done) begin
         rsp_pos_ff  <= POS_W'(pos_in);
         rsp_word_ff <= word_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_read_word       = rsp_word_ff;

   tccs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   `TCCS_ASSERT(a_accept_busy, accept |=> busy, "accepted transaction did not raise busy")
   `TCCS_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "result strobe held two cycles")
   `TCCS_ASSERT(a_move_src, move_vld_ff |-> $past(state_ff == S_SCROLL), "move write without scroll read")
   `TCCS_ASSERT(a_rsp_follows, rsp_valid |-> $past(busy), "result without a transaction at work")
   `TCCS_ASSERT_ALWAYS(a_cursor_range, reset || (col_ff <= COL_LAST && row_ff <= ROW_LAST), "cursor off screen")

endmodule
